// ===== rtl/core/pprb_pkg.sv =====
// Package for the primitive policy run builder: counter widths, policy
// constants, configuration register codes and the run record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pprb_pkg;

  // Width of the span position and run length counters (8 to 32)
  localparam int unsigned COUNT_W = 32;

  // Alpha in Q1.15 below this counts as fractional (alpha below 0.999)
  localparam logic [15:0] ALPHA_FRAC_LIMIT = 16'd32736;

  // Result queue depth: room for two records of one transaction plus slack
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIRST_PRIM   = 2'd0,
    CFG_FIRST_INDEX  = 2'd1,
    CFG_POLICY_MASK  = 2'd2,
    CFG_MAX_RUNS     = 2'd3
  } cfg_reg_e;

  // Result status codes
  localparam logic STATUS_RUN   = 1'b0;
  localparam logic STATUS_LIMIT = 1'b1;

  // One result record
  typedef struct packed {
    logic        status;
    logic [31:0] run_start_primitive;
    logic [31:0] run_start_index;
    logic [31:0] run_length;
    logic [31:0] run_index_count;
    logic [3:0]  run_policy;
    logic        end_of_span;
  } run_rec_t;

  // Three vertex indexes per primitive, modulo 2^32
  function automatic logic [31:0] times3(input logic [31:0] v);
    return (v << 1) + v;
  endfunction

  // Build a run record from the run's start, length and policy
  function automatic run_rec_t make_run(input logic [31:0] start_prim,
                                        input logic [31:0] start_idx,
                                        input logic [31:0] len,
                                        input logic [3:0]  pol,
                                        input logic        eos);
    run_rec_t r;
    r.status              = STATUS_RUN;
    r.run_start_primitive = start_prim;
    r.run_start_index     = start_idx;
    r.run_length          = len;
    r.run_index_count     = times3(len);
    r.run_policy          = pol;
    r.end_of_span         = eos;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/primitive_policy_run_builder.sv =====
// Primitive policy run builder: classifies primitives, groups them into runs
// and queues run records. Depends on pprb_pkg.
//
// Timing: a record is queued as the transaction closing its run is accepted
// and is readable in the next cycle. Throughput: one primitive per cycle while
// the output side drains; input ready needs two free slots in the four-entry
// result queue, since one primitive may close a run and end the span at once.
// Reset: asynchronous, active low; clears span state and the queue and loads
// the register defaults (policy mask 15, run limit 16). No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module primitive_policy_run_builder
  import pprb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // primitive input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        reflection_only_i,
  input  wire logic        material_present_i,
  input  wire logic        one_way_i,
  input  wire logic        no_shadow_i,
  input  wire logic        alpha_clip_i,
  input  wire logic [15:0] alpha_i,
  input  wire logic        last_primitive_i,
  // run record output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic [31:0]      run_start_primitive_o,
  output logic [31:0]      run_start_index_o,
  output logic [31:0]      run_length_o,
  output logic [31:0]      run_index_count_o,
  output logic [3:0]       run_policy_o,
  output logic             end_of_span_o
);

  // Configuration registers
  logic [31:0] first_prim_q;
  logic [31:0] first_index_q;
  logic [3:0]  policy_mask_q;
  logic [15:0] max_runs_q;

  // Span state
  logic               run_open_q,   run_open_d;
  logic [31:0]        open_sp_q,    open_sp_d;
  logic [31:0]        open_si_q,    open_si_d;
  logic [COUNT_W-1:0] open_len_q,   open_len_d;
  logic [3:0]         open_pol_q,   open_pol_d;
  logic [15:0]        runs_q,       runs_d;
  logic [COUNT_W-1:0] span_pos_q,   span_pos_d;
  logic               span_fail_q,  span_fail_d;

  // Result queue
  run_rec_t            queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  logic        in_fire, out_fire;
  logic [3:0]  policy;
  logic        starts_new, limit_hit;
  logic [31:0] start_prim, start_idx;
  logic [1:0]  n_push;
  run_rec_t    rec_a, rec_b, rec_last;

  assign in_ready_o = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_prim_q  <= '0;
      first_index_q <= '0;
      policy_mask_q <= 4'hF;
      max_runs_q    <= 16'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FIRST_PRIM:  first_prim_q  <= cfg_data_i;
        CFG_FIRST_INDEX: first_index_q <= cfg_data_i;
        CFG_POLICY_MASK: policy_mask_q <= cfg_data_i[3:0];
        CFG_MAX_RUNS:    max_runs_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Classify the primitive and mask its policy
  always_comb begin
    policy    = '0;
    policy[0] = reflection_only_i;
    if (material_present_i) begin
      policy[1] = one_way_i;
      policy[2] = no_shadow_i;
      policy[3] = alpha_clip_i || (alpha_i < ALPHA_FRAC_LIMIT);
    end
    policy = policy & policy_mask_q;
  end

  assign starts_new = !run_open_q || ((open_pol_q == '0) != (policy == '0));
  assign limit_hit  = starts_new && (runs_q >= max_runs_q);
  assign start_prim = first_prim_q + 32'(span_pos_q);
  assign start_idx  = first_index_q + times3(32'(span_pos_q));

  // Update span state and form the records of this transaction
  always_comb begin
    run_open_d  = run_open_q;
    open_sp_d   = open_sp_q;
    open_si_d   = open_si_q;
    open_len_d  = open_len_q;
    open_pol_d  = open_pol_q;
    runs_d      = runs_q;
    span_pos_d  = span_pos_q;
    span_fail_d = span_fail_q;
    n_push      = 2'd0;
    rec_a       = '0;
    rec_b       = '0;
    rec_last    = '0;

    if (in_fire) begin
      if (span_fail_q) begin
        // drop the rest of a failed span
        if (last_primitive_i) begin
          span_fail_d = 1'b0;
        end
      end else if (limit_hit) begin
        // emit the single error record
        rec_a.status      = STATUS_LIMIT;
        rec_a.end_of_span = 1'b1;
        n_push            = 2'd1;
        span_fail_d       = !last_primitive_i;
      end else begin
        if (starts_new && run_open_q) begin
          rec_a  = make_run(open_sp_q, open_si_q, 32'(open_len_q), open_pol_q, 1'b0);
          n_push = 2'd1;
        end
        if (starts_new) begin
          run_open_d = 1'b1;
          open_sp_d  = start_prim;
          open_si_d  = start_idx;
          open_len_d = COUNT_W'(1);
          open_pol_d = policy;
          runs_d     = runs_q + 16'd1;
        end else begin
          open_pol_d = open_pol_q | policy;
          open_len_d = open_len_q + COUNT_W'(1);
        end
        span_pos_d = span_pos_q + COUNT_W'(1);
        // close the open run at the end of the span
        if (last_primitive_i) begin
          rec_last = make_run(open_sp_d, open_si_d, 32'(open_len_d), open_pol_d, 1'b1);
          if (n_push == 2'd0) begin
            rec_a = rec_last;
          end else begin
            rec_b = rec_last;
          end
          n_push = n_push + 2'd1;
        end
      end

      // clear the span after its last primitive
      if (last_primitive_i) begin
        run_open_d  = 1'b0;
        open_sp_d   = '0;
        open_si_d   = '0;
        open_len_d  = '0;
        open_pol_d  = '0;
        runs_d      = '0;
        span_pos_d  = '0;
        span_fail_d = 1'b0;
      end
    end
  end

  // Hold span state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q  <= 1'b0;
      open_sp_q   <= '0;
      open_si_q   <= '0;
      open_len_q  <= '0;
      open_pol_q  <= '0;
      runs_q      <= '0;
      span_pos_q  <= '0;
      span_fail_q <= 1'b0;
    end else begin
      run_open_q  <= run_open_d;
      open_sp_q   <= open_sp_d;
      open_si_q   <= open_si_d;
      open_len_q  <= open_len_d;
      open_pol_q  <= open_pol_d;
      runs_q      <= runs_d;
      span_pos_q  <= span_pos_d;
      span_fail_q <= span_fail_d;
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(n_push) - QCNT_W'(out_fire);
    end
  end

  // Store records
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= rec_a;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= rec_b;
    end
  end

  // Drive the head record
  assign status_o              = queue_q[rd_ptr_q].status;
  assign run_start_primitive_o = queue_q[rd_ptr_q].run_start_primitive;
  assign run_start_index_o     = queue_q[rd_ptr_q].run_start_index;
  assign run_length_o          = queue_q[rd_ptr_q].run_length;
  assign run_index_count_o     = queue_q[rd_ptr_q].run_index_count;
  assign run_policy_o          = queue_q[rd_ptr_q].run_policy;
  assign end_of_span_o         = queue_q[rd_ptr_q].end_of_span;

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // A failed span produces nothing until it ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && span_fail_q) |-> (n_push == 2'd0))
    else $error("record pushed inside a failed span");

  // Two records only at the end of a span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push == 2'd2) |-> (in_fire && last_primitive_i && rec_b.end_of_span))
    else $error("double push away from span end");

  // Error record ends the span and arms the drop state unless it was last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !span_fail_q && limit_hit && !last_primitive_i) |=> span_fail_q)
    else $error("run limit did not fail the span");

  // Span end leaves no open run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_primitive_i) |=> (!run_open_q && runs_q == '0))
    else $error("span state not cleared");

endmodule

`default_nettype wire
